// ----- src/lgc_pkg.sv -----
// lgc_pkg: shared types and constants for the glyph slot LRU cache
// used by lgc_cell and lru_glyph_slot_cache; no dependencies
`timescale 1ns / 1ps

package lgc_pkg;

    // field widths fixed by the interface
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int CAP_W    = 5;

    // default number of tag entries
    localparam int DEFAULT_ENTRIES = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd3;

    // update applied to the row of cells
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_HIT        = 3'd1,
        OP_FILL       = 3'd2,
        OP_EVICT_OK   = 3'd3,
        OP_EVICT_FAIL = 3'd4
    } op_t;

    // search flags handed from cell to cell
    typedef struct packed {
        logic hit;
        logic free;
        logic victim;
    } find_t;

endpackage

// ----- src/lgc_cell.sv -----
// lgc_cell: one tag entry (tag, valid, recency rank) of the LRU row
// depends on lgc_pkg; chained by lru_glyph_slot_cache
`timescale 1ns / 1ps

module lgc_cell #(
    parameter int IDX_W   = 4,
    parameter int INDEX   = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // broadcast request and update
    input  logic                    clear,
    input  lgc_pkg::op_t            op,
    input  logic [IDX_W-1:0]        sel_idx,
    input  logic [IDX_W-1:0]        old_age,
    input  logic [IDX_W-1:0]        count_m1,
    input  logic [lgc_pkg::CP_W-1:0] cp,
    // search chain from the lower neighbor
    input  lgc_pkg::find_t          find_in,
    input  logic [IDX_W-1:0]        hit_idx_in,
    input  logic [IDX_W-1:0]        hit_age_in,
    input  logic [IDX_W-1:0]        free_idx_in,
    input  logic [IDX_W-1:0]        vic_idx_in,
    input  logic [lgc_pkg::CP_W-1:0] vic_tag_in,
    // search chain to the upper neighbor
    output lgc_pkg::find_t          find_out,
    output logic [IDX_W-1:0]        hit_idx_out,
    output logic [IDX_W-1:0]        hit_age_out,
    output logic [IDX_W-1:0]        free_idx_out,
    output logic [IDX_W-1:0]        vic_idx_out,
    output logic [lgc_pkg::CP_W-1:0] vic_tag_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                     valid_reg;
    logic                     valid_next;
    logic [lgc_pkg::CP_W-1:0] tag_reg;
    logic [lgc_pkg::CP_W-1:0] tag_next;
    logic [IDX_W-1:0]         age_reg;
    logic [IDX_W-1:0]         age_next;
    logic                     is_sel;
    logic                     my_hit;
    logic                     my_free;
    logic                     my_vic;

    assign is_sel = (sel_idx == MY_IDX);

    // local match flags
    assign my_hit  = valid_reg && (tag_reg == cp);
    assign my_free = !valid_reg;
    assign my_vic  = valid_reg && (age_reg == count_m1);

    // pass the search on, lowest index wins
    assign find_out.hit    = find_in.hit | my_hit;
    assign find_out.free   = find_in.free | my_free;
    assign find_out.victim = find_in.victim | my_vic;
    assign hit_idx_out  = find_in.hit ? hit_idx_in : MY_IDX;
    assign hit_age_out  = find_in.hit ? hit_age_in : age_reg;
    assign free_idx_out = find_in.free ? free_idx_in : MY_IDX;
    assign vic_idx_out  = find_in.victim ? vic_idx_in : MY_IDX;
    assign vic_tag_out  = find_in.victim ? vic_tag_in : tag_reg;

    // next entry state
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        age_next   = age_reg;
        unique case (op)
            lgc_pkg::OP_HIT:
            begin
                if (is_sel)
                    age_next = '0;
                else if (valid_reg && (age_reg < old_age))
                    age_next = age_reg + IDX_W'(1);
            end
            lgc_pkg::OP_EVICT_OK:
            begin
                if (is_sel)
                begin
                    age_next = '0;
                    tag_next = cp;
                end
                else if (valid_reg && (age_reg < old_age))
                    age_next = age_reg + IDX_W'(1);
            end
            lgc_pkg::OP_FILL:
            begin
                if (is_sel)
                begin
                    valid_next = 1'b1;
                    tag_next   = cp;
                    age_next   = '0;
                end
                else if (valid_reg)
                    age_next = age_reg + IDX_W'(1);
            end
            lgc_pkg::OP_EVICT_FAIL:
            begin
                if (is_sel)
                    valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
        if (clear)
            valid_next = 1'b0;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // tag and rank, read only while valid
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        age_reg <= age_next;
    end

endmodule

// ----- src/lru_glyph_slot_cache.sv -----
// lru_glyph_slot_cache: fully associative LRU tag store for glyph slots
// depends on lgc_pkg and lgc_cell (one cell per entry in a search chain)
`timescale 1ns / 1ps

// channel  | dir | width | beat contents (low bit first)
// s_*      | in  | 24    | codepoint[20:0], load_ok[21], zero pad
// m_*      | out | 32    | status[1:0], slot[5:2], evicted_valid[6],
//          |     |       | evicted_codepoint[27:7], zero pad
// cfg_*    | in  | 5     | capacity; any write clears all entries
//
// one request per cycle sustained while m_tready is high; a result is offered
// once its beat has passed the request register, then the result register
// the lookup, victim pick and rank update are one pass along the cell chain
// reset leaves capacity at zero (disabled) and all entries invalid
// with m_tready low the result holds and one more request waits in the
// request register; cfg_ready is always high

module lru_glyph_slot_cache #(
    parameter int ENTRIES = lgc_pkg::DEFAULT_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // codepoint[20:0], load_ok[21]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status, slot, evicted_valid, evicted_codepoint
    // capacity write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // capacity
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lgc_pkg::CAP_W) ? CNT_W : lgc_pkg::CAP_W;
    localparam int CP_W  = lgc_pkg::CP_W;

    // control and request registers
    logic [lgc_pkg::CAP_W-1:0]    capacity_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         req_valid_reg;
    logic [CP_W-1:0]              req_cp_reg;
    logic                         req_ok_reg;

    // result register
    logic                         out_valid_reg;
    logic [lgc_pkg::STATUS_W-1:0] out_status_reg;
    logic [lgc_pkg::SLOT_W-1:0]   out_slot_reg;
    logic                         out_ev_reg;
    logic [CP_W-1:0]              out_evcp_reg;

    // decision
    logic                         fire;
    logic                         s_fire;
    logic                         cfg_fire;
    logic                         disabled;
    logic                         has_room;
    lgc_pkg::op_t                 op;
    lgc_pkg::op_t                 cell_op;
    logic [IDX_W-1:0]             sel_idx;
    logic [IDX_W-1:0]             old_age;
    logic [IDX_W-1:0]             count_m1;
    logic [lgc_pkg::STATUS_W-1:0] status;
    logic [lgc_pkg::SLOT_W-1:0]   slot;
    logic                         ev;
    logic [CP_W-1:0]              evcp;

    // search chain nodes
    lgc_pkg::find_t               find_c [0:ENTRIES];
    logic [IDX_W-1:0]             hit_idx_c [0:ENTRIES];
    logic [IDX_W-1:0]             hit_age_c [0:ENTRIES];
    logic [IDX_W-1:0]             free_idx_c [0:ENTRIES];
    logic [IDX_W-1:0]             vic_idx_c [0:ENTRIES];
    logic [CP_W-1:0]              vic_tag_c [0:ENTRIES];

    // handshakes
    assign fire      = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !req_valid_reg || fire;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // chain head
    assign find_c[0]     = '0;
    assign hit_idx_c[0]  = '0;
    assign hit_age_c[0]  = '0;
    assign free_idx_c[0] = '0;
    assign vic_idx_c[0]  = '0;
    assign vic_tag_c[0]  = '0;

    assign count_m1 = IDX_W'(count_reg - CNT_W'(1));
    assign cell_op  = fire ? op : lgc_pkg::OP_NONE;

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lgc_cell #(
            .IDX_W   (IDX_W),
            .INDEX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .clear        (cfg_fire),
            .op           (cell_op),
            .sel_idx      (sel_idx),
            .old_age      (old_age),
            .count_m1     (count_m1),
            .cp           (req_cp_reg),
            .find_in      (find_c[i]),
            .hit_idx_in   (hit_idx_c[i]),
            .hit_age_in   (hit_age_c[i]),
            .free_idx_in  (free_idx_c[i]),
            .vic_idx_in   (vic_idx_c[i]),
            .vic_tag_in   (vic_tag_c[i]),
            .find_out     (find_c[i+1]),
            .hit_idx_out  (hit_idx_c[i+1]),
            .hit_age_out  (hit_age_c[i+1]),
            .free_idx_out (free_idx_c[i+1]),
            .vic_idx_out  (vic_idx_c[i+1]),
            .vic_tag_out  (vic_tag_c[i+1])
        );
    end

    // room below the effective capacity (capacity saturates at ENTRIES)
    assign disabled = (capacity_reg == '0);
    assign has_room = (CMP_W'(count_reg) < CMP_W'(capacity_reg))
                   && (CMP_W'(count_reg) < CMP_W'(ENTRIES));

    // hit, fill or evict decision
    always_comb
    begin
        op      = lgc_pkg::OP_NONE;
        sel_idx = '0;
        old_age = '0;
        status  = lgc_pkg::ST_DISABLED;
        slot    = '0;
        ev      = 1'b0;
        evcp    = '0;
        if (disabled)
        begin
            status = lgc_pkg::ST_DISABLED;
        end
        else if (find_c[ENTRIES].hit)
        begin
            op      = lgc_pkg::OP_HIT;
            sel_idx = hit_idx_c[ENTRIES];
            old_age = hit_age_c[ENTRIES];
            status  = lgc_pkg::ST_HIT;
            slot    = lgc_pkg::SLOT_W'(hit_idx_c[ENTRIES]);
        end
        else if (has_room)
        begin
            sel_idx = free_idx_c[ENTRIES];
            if (req_ok_reg)
            begin
                op     = lgc_pkg::OP_FILL;
                status = lgc_pkg::ST_LOADED;
                slot   = lgc_pkg::SLOT_W'(free_idx_c[ENTRIES]);
            end
            else
                status = lgc_pkg::ST_FAILED;
        end
        else
        begin
            sel_idx = vic_idx_c[ENTRIES];
            old_age = count_m1;
            ev      = 1'b1;
            evcp    = vic_tag_c[ENTRIES];
            if (req_ok_reg)
            begin
                op     = lgc_pkg::OP_EVICT_OK;
                status = lgc_pkg::ST_LOADED;
                slot   = lgc_pkg::SLOT_W'(vic_idx_c[ENTRIES]);
            end
            else
            begin
                op     = lgc_pkg::OP_EVICT_FAIL;
                status = lgc_pkg::ST_FAILED;
            end
        end
    end

    // valid entry count
    always_comb
    begin
        count_next = count_reg;
        if (cfg_fire)
            count_next = '0;
        else if (cell_op == lgc_pkg::OP_FILL)
            count_next = count_reg + CNT_W'(1);
        else if (cell_op == lgc_pkg::OP_EVICT_FAIL)
            count_next = count_reg - CNT_W'(1);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            count_reg     <= '0;
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
                capacity_reg <= cfg_data;
            count_reg <= count_next;
            if (s_fire)
                req_valid_reg <= 1'b1;
            else if (fire)
                req_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_cp_reg <= s_tdata[CP_W-1:0];
            req_ok_reg <= s_tdata[CP_W];
        end
        if (fire)
        begin
            out_status_reg <= status;
            out_slot_reg   <= slot;
            out_ev_reg     <= ev;
            out_evcp_reg   <= evcp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_evcp_reg, out_ev_reg, out_slot_reg, out_status_reg};

endmodule
